/* rtl/core/hrhp_pkg.sv */
// Shared types and constants for the HTTP request header parser.
`timescale 1ns / 1ps

package hrhp_pkg;

  localparam int unsigned MaxFieldLenDefault = 1023;
  localparam int unsigned LenW = 10;

  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseOfs = 8'h20;

  typedef enum logic [4:0] {
    S_INIT, S_G, S_GE, S_GET, S_SP1, S_RES, S_SP2,
    S_H, S_HT, S_HTT, S_HTTP, S_SLASH, S_ONE, S_DOT, S_VER, S_RLCR,
    S_BOL, S_NAME, S_COLON, S_LEAD, S_VAL, S_HCR, S_ECR, S_DONE, S_ERR
  } parse_state_e;

  typedef enum logic [2:0] {
    ROLE_FIXED  = 3'd0,
    ROLE_RES    = 3'd1,
    ROLE_SEP    = 3'd2,
    ROLE_NAME   = 3'd3,
    ROLE_COLON  = 3'd4,
    ROLE_VALUE  = 3'd5,
    ROLE_VAL_CR = 3'd6
  } role_e;

  typedef enum logic [1:0] {
    STAT_PARSING  = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_ERROR    = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    role_e            role;
    logic [7:0]       byte_out;
    logic [LenW-1:0]  name_len;
    logic [LenW-1:0]  value_len;
  } result_t;

endpackage

/* rtl/core/http_request_header_parser.sv */
// Top level of the HTTP request header parser: input register, parser step, result register.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    byte_in_i
// result    out_valid_o / out_stall_i  status_o, role_o, byte_out_o,
//                                      name_len_o, value_len_o
//
// One word in and one word out per cycle, sustained while out_stall_i is low;
// out_valid_o rises once the accepted word has passed the input register, then the result register.
// The rate is set by the combinational parser step between the two registers.
// Reset clears the parser state, both length counters and both valid flags.
// A stall on the result side holds the result register and, once the input
// register is also full, raises in_stall_o in the same cycle.

module http_request_header_parser import hrhp_pkg::*; #(
  parameter int unsigned MAX_FIELD_LEN = MaxFieldLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] role_o,
  output logic [7:0] byte_out_o,
  output logic [9:0] name_len_o,
  output logic [9:0] value_len_o
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       step;
  result_t    step_res;
  result_t    out_res;

  // Advance a held byte through the parser whenever the result register frees.
  assign step = held_valid && out_free;

  hrhp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .byte_in_i  (byte_in_i),
    .take_i     (step),
    .in_stall_o (in_stall_o),
    .full_o     (held_valid),
    .byte_o     (held_byte)
  );

  // Update parser state only on the cycle the word moves into the result register.
  hrhp_fsm #(
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (held_byte),
    .result_o (step_res)
  );

  hrhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (held_valid),
    .result_i    (step_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign status_o    = out_res.status;
  assign role_o      = out_res.role;
  assign byte_out_o  = out_res.byte_out;
  assign name_len_o  = out_res.name_len;
  assign value_len_o = out_res.value_len;

endmodule

/* rtl/core/hrhp_in_reg.sv */
// Input register stage: holds one request byte until the parser step takes it.
`timescale 1ns / 1ps

module hrhp_in_reg import hrhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] byte_in_i,
  input  logic       take_i,
  output logic       in_stall_o,
  output logic       full_o,
  output logic [7:0] byte_o
);

  logic       full_q, full_d;
  logic [7:0] byte_q;

  // Stall only while a held byte cannot move on this cycle.
  assign in_stall_o = full_q && !take_i;

  always_comb begin
    full_d = full_q;
    if (take_i) full_d = 1'b0;
    if (in_valid_i && !in_stall_o) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
    end
  end

  assign full_o = full_q;
  assign byte_o = byte_q;

endmodule

/* rtl/core/hrhp_fsm.sv */
// Parser state machine with saturating name and value length counters.
`timescale 1ns / 1ps

module hrhp_fsm import hrhp_pkg::*; #(
  parameter int unsigned MAX_FIELD_LEN = MaxFieldLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  localparam int unsigned CntW = $clog2(MAX_FIELD_LEN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FIELD_LEN);

  parse_state_e    state_q, state_d;
  logic [CntW-1:0] name_cnt_q, name_cnt_d;
  logic [CntW-1:0] val_cnt_q, val_cnt_d;
  logic [CntW-1:0] nl, vl;
  logic [CntW+LenW-1:0] nl_ext, vl_ext;
  role_e           role;
  logic            crlf;
  logic [CntW-1:0] name_inc, val_inc;

  assign crlf     = (byte_i == ChCr) || (byte_i == ChLf);
  assign name_inc = (name_cnt_q < CntMax) ? name_cnt_q + CntW'(1) : CntMax;
  assign val_inc  = (val_cnt_q < CntMax) ? val_cnt_q + CntW'(1) : CntMax;

  always_comb begin
    state_d    = state_q;
    name_cnt_d = name_cnt_q;
    val_cnt_d  = val_cnt_q;
    role       = ROLE_FIXED;
    nl         = '0;
    vl         = '0;
    case (state_q)
      S_INIT:  state_d = (byte_i == ChG) ? S_G : S_ERR;
      S_G:     state_d = (byte_i == ChE) ? S_GE : S_ERR;
      S_GE:    state_d = (byte_i == ChT) ? S_GET : S_ERR;
      S_GET: begin
        role    = ROLE_SEP;
        state_d = (byte_i == ChSpace) ? S_SP1 : S_ERR;
      end
      S_SP1, S_RES: begin
        if (crlf) begin
          role    = ROLE_SEP;
          state_d = S_ERR;
        end else if (byte_i == ChSpace) begin
          role    = ROLE_SEP;
          state_d = (state_q == S_SP1) ? S_SP1 : S_SP2;
        end else begin
          role    = ROLE_RES;
          state_d = S_RES;
        end
      end
      S_SP2:   state_d = (byte_i == ChH) ? S_H : S_ERR;
      S_H:     state_d = (byte_i == ChT) ? S_HT : S_ERR;
      S_HT:    state_d = (byte_i == ChT) ? S_HTT : S_ERR;
      S_HTT:   state_d = (byte_i == ChP) ? S_HTTP : S_ERR;
      S_HTTP:  state_d = (byte_i == ChSlash) ? S_SLASH : S_ERR;
      S_SLASH: state_d = (byte_i == ChOne) ? S_ONE : S_ERR;
      S_ONE:   state_d = (byte_i == ChDot) ? S_DOT : S_ERR;
      S_DOT:   state_d = (byte_i == ChOne) ? S_VER : S_ERR;
      S_VER: begin
        role    = ROLE_SEP;
        state_d = (byte_i == ChCr) ? S_RLCR : S_ERR;
      end
      S_RLCR: begin
        role    = ROLE_SEP;
        state_d = (byte_i == ChLf) ? S_BOL : S_ERR;
      end
      S_BOL: begin
        if (byte_i == ChCr) begin
          role    = ROLE_SEP;
          state_d = S_ECR;
        end else if (byte_i == ChLf) begin
          role    = ROLE_SEP;
          state_d = S_ERR;
        end else begin
          role       = ROLE_NAME;
          name_cnt_d = CntW'(1);
          state_d    = S_NAME;
        end
      end
      S_NAME: begin
        if (crlf) begin
          role    = ROLE_SEP;
          state_d = S_ERR;
        end else if (byte_i == ChColon) begin
          role      = ROLE_COLON;
          val_cnt_d = '0;
          state_d   = S_COLON;
        end else begin
          role       = ROLE_NAME;
          name_cnt_d = name_inc;
        end
      end
      S_COLON, S_LEAD: begin
        if (byte_i == ChLf) begin
          role    = ROLE_SEP;
          state_d = S_ERR;
        end else if (byte_i == ChCr) begin
          role    = ROLE_VAL_CR;
          nl      = name_cnt_q;
          state_d = S_HCR;
        end else if (byte_i == ChSpace) begin
          role    = ROLE_SEP;
          state_d = S_LEAD;
        end else begin
          role      = ROLE_VALUE;
          val_cnt_d = CntW'(1);
          state_d   = S_VAL;
        end
      end
      S_VAL: begin
        if (byte_i == ChLf) begin
          role    = ROLE_SEP;
          state_d = S_ERR;
        end else if (byte_i == ChCr) begin
          role    = ROLE_VAL_CR;
          nl      = name_cnt_q;
          vl      = val_cnt_q;
          state_d = S_HCR;
        end else begin
          role      = ROLE_VALUE;
          val_cnt_d = val_inc;
        end
      end
      S_HCR: begin
        role    = ROLE_SEP;
        state_d = (byte_i == ChLf) ? S_BOL : S_ERR;
      end
      S_ECR: begin
        role    = ROLE_SEP;
        state_d = (byte_i == ChLf) ? S_DONE : S_ECR;
      end
      S_DONE:  state_d = S_DONE;
      default: state_d = S_ERR;
    endcase
  end

  assign nl_ext = {{LenW{1'b0}}, nl};
  assign vl_ext = {{LenW{1'b0}}, vl};

  always_comb begin
    result_o.role      = role;
    result_o.byte_out  = byte_i;
    if ((role == ROLE_NAME) && (byte_i >= ChUpA) && (byte_i <= ChUpZ)) begin
      result_o.byte_out = byte_i + CaseOfs;
    end
    result_o.name_len  = nl_ext[LenW-1:0];
    result_o.value_len = vl_ext[LenW-1:0];
    case (state_d)
      S_DONE:  result_o.status = STAT_COMPLETE;
      S_ERR:   result_o.status = STAT_ERROR;
      default: result_o.status = STAT_PARSING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      name_cnt_q <= '0;
      val_cnt_q  <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      name_cnt_q <= name_cnt_d;
      val_cnt_q  <= val_cnt_d;
    end
  end

endmodule

/* rtl/core/hrhp_out_reg.sv */
// Result register: holds one parsed word until the consumer takes it.
`timescale 1ns / 1ps

module hrhp_out_reg import hrhp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    free_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) valid_d = load_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* rtl/core/hrhp_checker.sv */
// Port-level checker for the HTTP request header parser and its bind.
`timescale 1ns / 1ps

module hrhp_checker import hrhp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] byte_in_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [2:0] role_o,
  input logic [7:0] byte_out_o,
  input logic [9:0] name_len_o,
  input logic [9:0] value_len_o
);

  // Lengths only appear on a value-ending CR.
  a_len_only_on_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (role_o != ROLE_VAL_CR) |-> (name_len_o == '0) && (value_len_o == '0))
    else $error("lengths reported outside a value-ending CR");

  // A name character never comes out in upper case.
  a_name_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (role_o == ROLE_NAME) |-> !((byte_out_o >= ChUpA) && (byte_out_o <= ChUpZ)))
    else $error("upper-case name character on output");

  // A value-ending CR always leaves the parser still running.
  a_cr_parsing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (role_o == ROLE_VAL_CR) |-> (status_o == STAT_PARSING))
    else $error("value-ending CR with terminal status");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(role_o)
      && $stable(byte_out_o) && $stable(name_len_o) && $stable(value_len_o))
    else $error("stalled result word changed");

  // A stalled input word holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(byte_in_i))
    else $error("stalled input word changed");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .byte_in_i   (byte_in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .role_o      (role_o),
  .byte_out_o  (byte_out_o),
  .name_len_o  (name_len_o),
  .value_len_o (value_len_o)
);
